// ===== design/tint_pkg.sv =====
// Package for the table interpolator: request codes, register indexes and widths.
// No dependencies.
package tint_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned QuotW = 41;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_FORWARD = 2'd1,
    REQ_REVERSE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] REG_INTERP_LINEAR = 2'd1;
  localparam logic [1:0] REG_EXTRAP_LINEAR = 2'd2;
endpackage

// ===== design/tint_if.sv =====
// Channel interfaces for the table interpolator: request and result items.
// Depends on nothing.
interface tint_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  point_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] query_value;
  modport source (output valid, req_type, point_index, x_value, y_value, query_value,
                  input ready);
  modport sink (input valid, req_type, point_index, x_value, y_value, query_value,
                output ready);
endinterface

interface tint_res_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        result_valid;
  logic        saturated;
  modport source (output valid, result_value, result_valid, saturated, input ready);
  modport sink (input valid, result_value, result_valid, saturated, output ready);
endinterface

// ===== design/table_interpolator.sv =====
// Table interpolator top level: breakpoint memories, segment search sequencer,
// multiplier and restoring divider. Depends on tint_pkg and tint_if.
//
//  channel  direction  handshake     payload
//  req      in         valid/ready   req_type, point_index, x_value, y_value, query_value
//  res      out        valid/ready   result_value, result_valid, saturated
//  apb      in         psel/penable  point_count, interp_linear, extrap_linear
//
// A load or an idle request goes through S_OUT to the output register once it is accepted.
// A query reads the first two points (S_RD0, S_RD1), then tests one segment at a time
// (S_SEG, S_ENDS) and, when no segment holds q, the ends (S_ENDS2). A linear answer adds
// the multiply steps (S_MUL), the restoring division (S_DIV) and a saturation step (S_FIN).
// Reset clears the control state; the tables are undefined until loaded.
// One item is in work at a time; a waiting result stalls the input once the next is done.
module table_interpolator
  import tint_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  tint_req_if.sink    req,
  tint_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_SEG, S_ENDS, S_ENDS2, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  logic [6:0] point_count;
  logic       interp_linear;
  logic       extrap_linear;

  // Configuration port.
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_POINT_COUNT:   prdata = {25'd0, point_count};
      REG_INTERP_LINEAR: prdata = {31'd0, interp_linear};
      REG_EXTRAP_LINEAR: prdata = {31'd0, extrap_linear};
      default:           prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= 7'd2;
      interp_linear <= 1'b1;
      extrap_linear <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[1:0] == 2'b00) begin
        unique case (reg_idx)
          REG_POINT_COUNT:   point_count   <= pwdata[6:0];
          REG_INTERP_LINEAR: interp_linear <= pwdata[0];
          REG_EXTRAP_LINEAR: extrap_linear <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  // Effective point count, clamped to 1..MAX_POINTS.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (point_count == 7'd0) n_eff = CW'(1);
    else if (32'(point_count) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
    else n_eff = CW'(point_count);
  end

  // Breakpoint memory: one row holds x and y.
  logic [63:0]   mem [MAX_POINTS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [63:0]   mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  state_t state;
  logic   rev;
  logic signed [31:0] q;
  logic [CW-1:0] idx;
  logic signed [31:0] ka, va, kb, vb;     // previous and current key/value
  logic signed [31:0] k0, v0, k1, v1;     // first two points
  logic signed [31:0] kl, vl;             // last point
  logic signed [31:0] sa_k, sa_v, sb_k, sb_v; // chosen segment for linear
  logic signed [31:0] fin_value;
  logic         fin_rvalid, fin_sat;
  logic         out_valid;
  logic signed [31:0] out_value;
  logic         out_rvalid, out_sat;
  // Arithmetic.
  logic [32:0]  m1, m2, m3;
  logic         neg;
  logic [65:0]  prod;
  logic [1:0]   mstep;
  logic [127:0] dshift;
  logic [32:0]  rem;
  logic [QuotW-1:0] quo;
  logic [6:0]   dcnt;

  logic signed [31:0] rk, rv;
  assign rk = rev ? mem_rdata[31:0] : mem_rdata[63:32];
  assign rv = rev ? mem_rdata[63:32] : mem_rdata[31:0];

  assign req.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.result_value = out_value;
  assign res.result_valid = out_rvalid;
  assign res.saturated = out_sat;

  always_comb begin
    mem_we    = req.valid && req.ready && (req.req_type == REQ_LOAD)
                && (32'(req.point_index) < MAX_POINTS);
    mem_waddr = AW'(req.point_index);
    mem_wdata = {req.x_value, req.y_value};
    mem_raddr = AW'(idx);
  end

  // Segment tests on the current pair (ka, kb) against q.
  logic hit_seg, hit_eq;
  assign hit_seg = ((q >= ka) && (q < kb)) || ((q <= ka) && (q > kb));
  assign hit_eq  = (q == ka) && (q == kb);

  logic signed [33:0] d1, d2, d3;
  assign d1 = 34'(sb_v) - 34'(sa_v);
  assign d2 = 34'(q) - 34'(sa_k);
  assign d3 = 34'(sb_k) - 34'(sa_k);

  logic [33:0] rem_sh;
  logic [33:0] rem_diff;
  logic [QuotW:0] quo_next;
  assign rem_sh   = {rem, dshift[127]};
  assign rem_diff = rem_sh - {1'b0, m3};
  always_comb begin
    quo_next = {quo, 1'b0};
    if (rem_sh >= {1'b0, m3}) quo_next[0] = 1'b1;
    if (quo_next > (QuotW+1)'(42'h100_0000_0000)) quo_next = (QuotW+1)'(42'h100_0000_0000);
  end

  logic signed [42:0] sum;
  assign sum = neg ? (43'(sa_v) - 43'(quo)) : (43'(sa_v) + 43'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            rev <= (req.req_type == REQ_REVERSE);
            q   <= req.query_value;
            idx <= '0;
            if (req.req_type == REQ_FORWARD || req.req_type == REQ_REVERSE) begin
              state <= S_RD0;
            end else begin
              fin_value  <= '0;
              fin_rvalid <= 1'b0;
              fin_sat    <= 1'b0;
              state      <= S_OUT;
            end
          end
        end
        S_RD0: begin
          idx   <= CW'(1);
          state <= S_RD1;
        end
        S_RD1: begin
          k0 <= rk; v0 <= rv; ka <= rk; va <= rv;
          kl <= rk; vl <= rv;
          if (n_eff == CW'(1)) begin
            fin_value <= rv; fin_rvalid <= 1'b1; fin_sat <= 1'b0;
            state <= S_OUT;
          end else begin
            idx   <= CW'(2);
            state <= S_SEG;
          end
        end
        S_SEG: begin
          // Pair (ka,va) with the row just read.
          if (idx == CW'(2)) begin k1 <= rk; v1 <= rv; end
          kb <= rk; vb <= rv;
          state <= S_ENDS;
        end
        S_ENDS: begin
          kl <= kb; vl <= vb;
          if (hit_seg) begin
            if (!interp_linear || ka == kb) begin
              fin_value <= va; fin_rvalid <= 1'b1; fin_sat <= 1'b0;
              state <= S_OUT;
            end else begin
              sa_k <= ka; sa_v <= va; sb_k <= kb; sb_v <= vb;
              state <= S_MUL; mstep <= '0;
            end
          end else if (hit_eq) begin
            fin_value <= va; fin_rvalid <= 1'b1; fin_sat <= 1'b0;
            state <= S_OUT;
          end else if (idx >= n_eff) begin
            state <= S_ENDS2;
          end else begin
            ka <= kb; va <= vb;
            idx <= idx + CW'(1);
            state <= S_SEG;
          end
        end
        S_ENDS2: begin
          // kl/vl is the last point; ka/va the one before it.
          if ((q < k0 && k0 < kl) || (q > k0 && k0 > kl)) begin
            if (!extrap_linear || k0 == k1) begin
              fin_value <= v0; fin_rvalid <= 1'b1; fin_sat <= 1'b0;
              state <= S_OUT;
            end else begin
              sa_k <= k0; sa_v <= v0; sb_k <= k1; sb_v <= v1;
              state <= S_MUL; mstep <= '0;
            end
          end else if ((q >= kl && kl > k0) || (q <= kl && kl < k0)) begin
            if (!extrap_linear || kl == ka) begin
              fin_value <= vl; fin_rvalid <= 1'b1; fin_sat <= 1'b0;
              state <= S_OUT;
            end else begin
              sa_k <= kl; sa_v <= vl; sb_k <= ka; sb_v <= va;
              state <= S_MUL; mstep <= '0;
            end
          end else begin
            fin_value <= '0; fin_rvalid <= 1'b0; fin_sat <= 1'b0;
            state <= S_OUT;
          end
        end
        S_MUL: begin
          // Magnitudes, then the product in a low 17-bit and a high 16-bit part of m2.
          case (mstep)
            2'd0: begin
              m1  <= d1[33] ? 33'(-d1) : 33'(d1);
              m2  <= d2[33] ? 33'(-d2) : 33'(d2);
              m3  <= d3[33] ? 33'(-d3) : 33'(d3);
              neg <= d1[33] ^ d2[33] ^ d3[33];
              mstep <= 2'd1;
            end
            2'd1: begin
              prod  <= 66'(m1 * m2[16:0]);
              mstep <= 2'd2;
            end
            2'd2: begin
              prod  <= prod + (66'(m1 * m2[32:17]) << 17);
              mstep <= 2'd3;
            end
            default: begin
              dshift <= {62'd0, prod};
              rem    <= '0;
              quo    <= '0;
              dcnt   <= '0;
              state  <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, m3}) rem <= rem_diff[32:0];
          else rem <= rem_sh[32:0];
          quo    <= quo_next[QuotW-1:0];
          dshift <= {dshift[126:0], 1'b0};
          dcnt   <= dcnt + 7'd1;
          if (dcnt == 7'd127) state <= S_FIN;
        end
        S_FIN: begin
          fin_rvalid <= 1'b1;
          if (sum > 43'sh0_7FFF_FFFF) begin
            fin_value <= 32'sh7FFF_FFFF; fin_sat <= 1'b1;
          end else if (sum < -43'sh0_8000_0000) begin
            fin_value <= 32'sh8000_0000; fin_sat <= 1'b1;
          end else begin
            fin_value <= sum[31:0]; fin_sat <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || (res.valid && res.ready)) begin
            out_valid  <= 1'b1;
            out_value  <= fin_value;
            out_rvalid <= fin_rvalid;
            out_sat    <= fin_sat;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
